// File: src/exponential_cohesive_traction_defines.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef EXPONENTIAL_COHESIVE_TRACTION_DEFINES_SVH
`define EXPONENTIAL_COHESIVE_TRACTION_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ECT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ect_pkg.sv
`timescale 1ns / 1ps

package ect_pkg;

    // Fixed-point formats
    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DMG_FRAC     = 30;
    localparam int SERIES_TERMS = 16;
    localparam int SER_STAGES   = 3 * SERIES_TERMS;
    localparam int POW_STAGES   = 31;

    localparam logic [30:0] DMG_ONE = 31'(1) << DMG_FRAC;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_INVERSE_LENGTH     = 2'd0,
        CFG_COHESIVE_STIFFNESS = 2'd1,
        CFG_CONTACT_STIFFNESS  = 2'd2,
        CFG_PENETRATION_ENABLE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [30:0] inverse_length;
        logic [30:0] cohesive_stiffness;
        logic [30:0] contact_stiffness;
        logic        penetration_enable;
    } t_cfg;

    // Fields that ride along the exponential pipeline
    typedef struct packed {
        logic [30:0] old_damage;
        logic [31:0] normal_sep;
        logic [31:0] normal_pen;
        logic [31:0] shear_sep_one;
        logic [31:0] shear_sep_two;
    } t_side;

    // One stage of the series evaluation
    typedef struct packed {
        t_side       side;
        logic        big;
        logic [4:0]  n;
        logic [31:0] f;
        logic [31:0] p;
        logic [31:0] q;
        logic [32:0] term;
        logic [33:0] pos;
        logic [32:0] neg;
    } t_series;

    // Exponential of the fraction, integer part still to apply
    typedef struct packed {
        t_side       side;
        logic        big;
        logic [4:0]  n;
        logic [32:0] r;
    } t_exp_item;

    typedef struct packed {
        logic [31:0] traction_normal;
        logic [31:0] traction_shear_one;
        logic [31:0] traction_shear_two;
        logic [30:0] damage_out;
        logic        damage_advanced;
        logic [30:0] secant_scale;
        logic [30:0] damage_slope;
        logic [31:0] normal_by_damage;
        logic [31:0] shear_one_by_damage;
        logic [31:0] shear_two_by_damage;
    } t_result;

    // exp(-1/2) by the truncated series, squared and rounded: exp(-1) in Q0.32
    function automatic logic [31:0] calc_e1();
        logic [32:0] term;
        logic [33:0] pos;
        logic [33:0] neg;
        logic [32:0] e;
        term = 33'h1_0000_0000;
        pos  = 34'(term);
        neg  = '0;
        for (int K = 1; K <= SERIES_TERMS; K++) begin
            term = 33'(((66'(term) * (66'(1) << 31)) >> 32) / 66'(K));
            if (K % 2 == 1) begin
                neg = neg + 34'(term);
            end else begin
                pos = pos + 34'(term);
            end
        end
        e = 33'(pos - neg);
        return 32'((66'(e) * 66'(e) + (66'(1) << 31)) >> 32);
    endfunction

    localparam logic [31:0] E1 = calc_e1();

    // Magnitude of a two's complement word
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // Round a Q16.16 product half away from zero and apply the sign
    function automatic logic signed [48:0] round_frac(input logic [62:0] prod,
                                                      input logic neg);
        logic [46:0] r;
        r = 47'((64'(prod) + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        return neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
    endfunction

    // Clamp to a signed DATA_WIDTH word
    function automatic logic [31:0] sat_dw(input logic signed [49:0] v);
        localparam logic signed [49:0] HI = 50'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
        localparam logic signed [49:0] LO = -HI - 50'sd1;
        if (v > HI) begin
            return 32'(HI);
        end else if (v < LO) begin
            return 32'(LO);
        end
        return 32'(v);
    endfunction

endpackage

// File: src/ect_exp_series.sv
`timescale 1ns / 1ps

module ect_exp_series import ect_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_eff_sep,
    input  logic [30:0] i_inv_len,
    input  t_side       i_side,
    output logic        o_valid,
    output t_exp_item   o_item
);

    t_series r_st  [0:SER_STAGES];
    logic    r_vld [0:SER_STAGES];
    logic [61:0] w_x;

    // Scale the separation into the exponent and split it
    assign w_x = 62'(i_eff_sep) * 62'(i_inv_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].side <= i_side;
            r_st[0].big  <= |w_x[61:37];
            r_st[0].n    <= w_x[36:32];
            r_st[0].f    <= w_x[31:0];
            r_st[0].p    <= '0;
            r_st[0].q    <= '0;
            r_st[0].term <= 33'h1_0000_0000;
            r_st[0].pos  <= 34'h1_0000_0000;
            r_st[0].neg  <= '0;
        end
    end

    // Three stages per series term: multiply, reciprocal, correct and accumulate
    for (genvar j = 0; j < SER_STAGES; j++) begin : g_stage
        localparam int K  = j / 3 + 1;
        localparam int PH = j % 3;
        localparam logic [33:0] RECIP = 34'((64'd1 << 33) / K);

        t_series     n_st;
        logic [36:0] w_qk;
        logic [36:0] w_rem;
        logic [31:0] w_qn;

        always_comb begin
            n_st  = r_st[j];
            w_qk  = 37'(r_st[j].q) * 37'(K);
            w_rem = 37'(r_st[j].p) - w_qk;
            w_qn  = (w_rem >= 37'(K)) ? r_st[j].q + 32'd1 : r_st[j].q;
            case (PH)
                0: begin
                    n_st.p = 32'((66'(r_st[j].term) * 66'(r_st[j].f)) >> 32);
                end
                1: begin
                    n_st.q = 32'((66'(r_st[j].p) * 66'(RECIP)) >> 33);
                end
                default: begin
                    n_st.term = 33'(w_qn);
                    if (K % 2 == 1) begin
                        n_st.neg = r_st[j].neg + 33'(w_qn);
                    end else begin
                        n_st.pos = r_st[j].pos + 34'(w_qn);
                    end
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1] <= n_st;
            end
        end
    end

    // Hand the series sum on with the integer part
    assign o_valid     = r_vld[SER_STAGES];
    assign o_item.side = r_st[SER_STAGES].side;
    assign o_item.big  = r_st[SER_STAGES].big;
    assign o_item.n    = r_st[SER_STAGES].n;
    assign o_item.r    = 33'(r_st[SER_STAGES].pos - 34'(r_st[SER_STAGES].neg));

endmodule

// File: src/ect_exp_power.sv
`timescale 1ns / 1ps

module ect_exp_power import ect_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_exp_item i_item,
    output logic      o_valid,
    output t_exp_item o_item
);

    t_exp_item r_pw  [0:POW_STAGES-1];
    logic      r_vld [0:POW_STAGES-1];

    // One rounded multiply by exp(-1) per stage while the stage index is below n
    for (genvar i = 0; i < POW_STAGES; i++) begin : g_stage
        t_exp_item w_src;
        logic      w_vld;
        t_exp_item n_pw;

        if (i == 0) begin : g_first
            assign w_src = i_item;
            assign w_vld = i_valid;
        end else begin : g_rest
            assign w_src = r_pw[i-1];
            assign w_vld = r_vld[i-1];
        end

        always_comb begin
            n_pw = w_src;
            if (5'(i) < w_src.n) begin
                n_pw.r = 33'((65'(w_src.r) * 65'(E1) + (65'(1) << 31)) >> 32);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pw[i] <= n_pw;
            end
        end
    end

    assign o_valid = r_vld[POW_STAGES-1];
    assign o_item  = r_pw[POW_STAGES-1];

endmodule

// File: src/ect_traction.sv
`timescale 1ns / 1ps

module ect_traction import ect_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_exp_item i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_result   o_result
);

    // Stage A: damage update
    t_side       r_a_side;
    logic [30:0] r_a_e;
    logic [30:0] r_a_dmg;
    logic        r_a_adv;
    logic        r_a_vld;

    logic [31:0] w_e_rnd;
    logic [30:0] w_e;
    logic [30:0] w_old;
    logic [30:0] w_trial;
    logic        w_adv;

    always_comb begin
        w_e_rnd = 32'((34'(i_item.r) + 34'd2) >> 2);
        if (i_item.big) begin
            w_e = '0;
        end else if (w_e_rnd > 32'(DMG_ONE)) begin
            w_e = DMG_ONE;
        end else begin
            w_e = 31'(w_e_rnd);
        end
        w_old   = (i_item.side.old_damage > DMG_ONE) ? DMG_ONE : i_item.side.old_damage;
        w_trial = DMG_ONE - w_e;
        w_adv   = w_trial > w_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_item.side;
            r_a_e    <= w_e;
            r_a_adv  <= w_adv;
            r_a_dmg  <= w_adv ? w_trial : w_old;
        end
    end

    // Stage B: secant scale and damage slope
    t_side       r_b_side;
    logic [30:0] r_b_dmg;
    logic        r_b_adv;
    logic [30:0] r_b_scale;
    logic [30:0] r_b_slope;
    logic        r_b_vld;

    logic [62:0] w_scale;
    logic [62:0] w_slope;

    assign w_scale = (63'(DMG_ONE - r_a_dmg) * 63'(i_cfg.cohesive_stiffness)
                      + (63'(1) << (DMG_FRAC - 1))) >> DMG_FRAC;
    assign w_slope = (63'(r_a_e) * 63'(i_cfg.inverse_length)
                      + (63'(1) << (DMG_FRAC - 1))) >> DMG_FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_side  <= r_a_side;
            r_b_dmg   <= r_a_dmg;
            r_b_adv   <= r_a_adv;
            r_b_scale <= 31'(w_scale);
            r_b_slope <= r_a_adv ? 31'(w_slope) : '0;
        end
    end

    // Stage C: magnitude products
    logic [30:0] r_c_dmg;
    logic        r_c_adv;
    logic [30:0] r_c_scale;
    logic [30:0] r_c_slope;
    logic [62:0] r_c_pn, r_c_pp, r_c_p1, r_c_p2, r_c_cn, r_c_c1, r_c_c2;
    logic        r_c_sn, r_c_sp, r_c_s1, r_c_s2;
    logic        r_c_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_dmg   <= r_b_dmg;
            r_c_adv   <= r_b_adv;
            r_c_scale <= r_b_scale;
            r_c_slope <= r_b_slope;
            r_c_pn <= 63'(r_b_scale) * 63'(mag32(r_b_side.normal_sep));
            r_c_pp <= 63'(i_cfg.contact_stiffness) * 63'(mag32(r_b_side.normal_pen));
            r_c_p1 <= 63'(r_b_scale) * 63'(mag32(r_b_side.shear_sep_one));
            r_c_p2 <= 63'(r_b_scale) * 63'(mag32(r_b_side.shear_sep_two));
            r_c_cn <= 63'(i_cfg.cohesive_stiffness) * 63'(mag32(r_b_side.normal_sep));
            r_c_c1 <= 63'(i_cfg.cohesive_stiffness) * 63'(mag32(r_b_side.shear_sep_one));
            r_c_c2 <= 63'(i_cfg.cohesive_stiffness) * 63'(mag32(r_b_side.shear_sep_two));
            r_c_sn <= r_b_side.normal_sep[31];
            r_c_sp <= r_b_side.normal_pen[31];
            r_c_s1 <= r_b_side.shear_sep_one[31];
            r_c_s2 <= r_b_side.shear_sep_two[31];
        end
    end

    // Stage D: round, add the penalty term, saturate
    t_result            r_d;
    logic               r_d_vld;
    logic signed [49:0] w_tn;
    logic signed [49:0] w_pen;

    assign w_pen = i_cfg.penetration_enable ? 50'(round_frac(r_c_pp, r_c_sp)) : '0;
    assign w_tn  = 50'(round_frac(r_c_pn, r_c_sn)) + w_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.traction_normal     <= sat_dw(w_tn);
            r_d.traction_shear_one  <= sat_dw(50'(round_frac(r_c_p1, r_c_s1)));
            r_d.traction_shear_two  <= sat_dw(50'(round_frac(r_c_p2, r_c_s2)));
            r_d.damage_out          <= r_c_dmg;
            r_d.damage_advanced     <= r_c_adv;
            r_d.secant_scale        <= r_c_scale;
            r_d.damage_slope        <= r_c_slope;
            r_d.normal_by_damage    <= sat_dw(50'(round_frac(r_c_cn, !r_c_sn)));
            r_d.shear_one_by_damage <= sat_dw(50'(round_frac(r_c_c1, !r_c_s1)));
            r_d.shear_two_by_damage <= sat_dw(50'(round_frac(r_c_c2, !r_c_s2)));
        end
    end

    assign o_valid  = r_d_vld;
    assign o_result = r_d;

endmodule

// File: src/exponential_cohesive_traction.sv
// Pipeline: an accepted item passes through 85 register stages before its result shows
// on o_m_tvalid: 48 for the 16-term series, 31 for the exp(-1) powers, 6 more.
// Throughput: one item per cycle; the pipeline halts only while its last stage and the
// output register both hold results that are not taken.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "exponential_cohesive_traction_defines.svh"

module exponential_cohesive_traction import ect_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // effective_sep, old_damage, normal_sep, normal_pen, shear_sep_one, shear_sep_two, pad
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // traction_normal, traction_shear_one, traction_shear_two, damage_out, damage_advanced,
    // secant_scale, damage_slope, normal_by_damage, shear_one_by_damage,
    // shear_two_by_damage, pad
    output logic [287:0] o_m_tdata
);

    t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_length     <= 31'd65536;
            r_cfg.cohesive_stiffness <= 31'd65536;
            r_cfg.contact_stiffness  <= '0;
            r_cfg.penetration_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INVERSE_LENGTH:     r_cfg.inverse_length     <= i_cfg_wdata;
                CFG_COHESIVE_STIFFNESS: r_cfg.cohesive_stiffness <= i_cfg_wdata;
                CFG_CONTACT_STIFFNESS:  r_cfg.contact_stiffness  <= i_cfg_wdata;
                CFG_PENETRATION_ENABLE: r_cfg.penetration_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic      w_en;
    logic      w_accept;
    t_side     w_side;
    logic      w_ser_vld;
    t_exp_item w_ser_item;
    logic      w_pow_vld;
    t_exp_item w_pow_item;
    logic      w_last_vld;
    t_result   w_last;
    logic      w_load;
    t_result   r_out;
    logic      r_out_vld;

    // Advance the pipeline unless a finished result has nowhere to go
    assign w_en       = !w_last_vld || !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign w_accept   = i_s_tvalid && w_en;

    assign w_side.old_damage    = i_s_tdata[61:31];
    assign w_side.normal_sep    = i_s_tdata[93:62];
    assign w_side.normal_pen    = i_s_tdata[125:94];
    assign w_side.shear_sep_one = i_s_tdata[157:126];
    assign w_side.shear_sep_two = i_s_tdata[189:158];

    ect_exp_series u_series (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_accept),
        .i_eff_sep (i_s_tdata[30:0]),
        .i_inv_len (r_cfg.inverse_length),
        .i_side    (w_side),
        .o_valid   (w_ser_vld),
        .o_item    (w_ser_item)
    );

    ect_exp_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ser_vld),
        .i_item  (w_ser_item),
        .o_valid (w_pow_vld),
        .o_item  (w_pow_item)
    );

    ect_traction u_traction (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_pow_vld),
        .i_item   (w_pow_item),
        .i_cfg    (r_cfg),
        .o_valid  (w_last_vld),
        .o_result (w_last)
    );

    // Output register: load when the last stage holds an item and the slot frees up
    assign w_load = w_last_vld && (!r_out_vld || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00,
                         r_out.shear_two_by_damage,
                         r_out.shear_one_by_damage,
                         r_out.normal_by_damage,
                         r_out.damage_slope,
                         r_out.secant_scale,
                         r_out.damage_advanced,
                         r_out.damage_out,
                         r_out.traction_shear_two,
                         r_out.traction_shear_one,
                         r_out.traction_normal};

    `ECT_ASSERT_SAME(a_damage_bound, r_out_vld, r_out.damage_out <= DMG_ONE, "damage above one")
    `ECT_ASSERT_SAME(a_slope_idle, r_out_vld && !r_out.damage_advanced, r_out.damage_slope == '0, "slope without advance")
    `ECT_ASSERT_SAME(a_advance_nonzero, r_out_vld && r_out.damage_advanced, r_out.damage_out != '0, "advanced to zero damage")
    `ECT_ASSERT_SAME(a_stall_cause, !w_en, w_last_vld && r_out_vld && !i_m_tready, "stall without a blocked result")
    `ECT_ASSERT_NEXT(a_load_shows, w_load, r_out_vld, "loaded result not shown")

endmodule

// File: verif/exponential_cohesive_traction_checker.sv
`timescale 1ns / 1ps

module exponential_cohesive_traction_checker import ect_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [191:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [287:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    localparam logic [63:0] DAMAGE_ONE = 64'd1 << DMG_FRAC;

    logic [30:0] inv_len;
    logic [30:0] coh_stiff;
    logic [30:0] pen_stiff;
    logic        pen_en;
    t_result     traction_queue[$];
    int          fail_count = 0;
    int          pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Alternating series for exp(-f), f in Q0.32
    function automatic logic [63:0] exp_frac(input logic [63:0] f);
        logic [127:0] prod;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        term = 64'd1 << 32;
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k <= 16; k++) begin
            prod = 128'(term) * 128'(f);
            term = 64'((prod >> 32) / 128'(k));
            if (k % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

    // exp(-x), x with 32 fractional bits, result Q2.30 capped at one
    function automatic logic [63:0] exp_q30(input logic [63:0] x);
        logic [63:0]  whole;
        logic [63:0]  r;
        logic [63:0]  e1;
        logic [127:0] prod;
        whole = x >> 32;
        if (whole >= 64'd32) begin
            return 64'd0;
        end
        r    = exp_frac({32'd0, x[31:0]});
        e1   = exp_frac(64'd1 << 31);
        prod = 128'(e1) * 128'(e1) + (128'd1 << 31);
        e1   = 64'(prod >> 32);
        for (int i = 0; i < int'(whole); i++) begin
            prod = 128'(r) * 128'(e1) + (128'd1 << 31);
            r    = 64'(prod >> 32);
        end
        r = (r + 64'd2) >> 2;
        return (r > DAMAGE_ONE) ? DAMAGE_ONE : r;
    endfunction

    // Q16.16 product, rounded half away from zero
    function automatic longint mul_q16(input logic [63:0] a, input longint b);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (b < 0) ? 64'(-b) : 64'(b);
        r   = (a * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (b < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_result predict_traction(input logic [191:0] d);
        t_result     res;
        logic [63:0] eff;
        logic [63:0] old;
        longint      sep_n;
        longint      pen_n;
        longint      sep_1;
        longint      sep_2;
        logic [63:0] e;
        logic [63:0] trial;
        logic [63:0] dmg;
        logic [63:0] scale;
        logic [63:0] slope;
        logic        adv;
        longint      tn;
        eff   = {33'd0, d[30:0]};
        old   = {33'd0, d[61:31]};
        sep_n = longint'($signed(d[93:62]));
        pen_n = longint'($signed(d[125:94]));
        sep_1 = longint'($signed(d[157:126]));
        sep_2 = longint'($signed(d[189:158]));
        // saturate damage above one first
        if (old > DAMAGE_ONE) begin
            old = DAMAGE_ONE;
        end
        e     = exp_q30(eff * {33'd0, inv_len});
        trial = DAMAGE_ONE - e;
        adv   = trial > old;
        dmg   = adv ? trial : old;
        scale = ((DAMAGE_ONE - dmg) * {33'd0, coh_stiff} + (64'd1 << (DMG_FRAC - 1)))
                >> DMG_FRAC;
        slope = adv ? (e * {33'd0, inv_len} + (64'd1 << (DMG_FRAC - 1))) >> DMG_FRAC
                    : 64'd0;
        tn = mul_q16(scale, sep_n);
        if (pen_en) begin
            tn = tn + mul_q16({33'd0, pen_stiff}, pen_n);
        end
        res.traction_normal     = clamp32(tn);
        res.traction_shear_one  = clamp32(mul_q16(scale, sep_1));
        res.traction_shear_two  = clamp32(mul_q16(scale, sep_2));
        res.damage_out          = dmg[30:0];
        res.damage_advanced     = adv;
        res.secant_scale        = scale[30:0];
        res.damage_slope        = slope[30:0];
        res.normal_by_damage    = clamp32(-mul_q16({33'd0, coh_stiff}, sep_n));
        res.shear_one_by_damage = clamp32(-mul_q16({33'd0, coh_stiff}, sep_1));
        res.shear_two_by_damage = clamp32(-mul_q16({33'd0, coh_stiff}, sep_2));
        return res;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Track configuration, predict on input, compare on output
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            inv_len   <= 31'd65536;
            coh_stiff <= 31'd65536;
            pen_stiff <= 31'd0;
            pen_en    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_INVERSE_LENGTH:     inv_len   <= i_cfg_wdata;
                    CFG_COHESIVE_STIFFNESS: coh_stiff <= i_cfg_wdata;
                    CFG_CONTACT_STIFFNESS:  pen_stiff <= i_cfg_wdata;
                    CFG_PENETRATION_ENABLE: pen_en    <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                traction_queue.push_back(predict_traction(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[31:0], i_m_tdata[63:32], i_m_tdata[95:64],
                       i_m_tdata[126:96], i_m_tdata[127], i_m_tdata[158:128],
                       i_m_tdata[189:159], i_m_tdata[221:190], i_m_tdata[253:222],
                       i_m_tdata[285:254]};
                if (traction_queue.size() == 0) begin
                    report("result item with nothing expected");
                end else begin
                    want = traction_queue.pop_front();
                    check_field("traction_normal", got.traction_normal,
                                want.traction_normal);
                    check_field("traction_shear_one", got.traction_shear_one,
                                want.traction_shear_one);
                    check_field("traction_shear_two", got.traction_shear_two,
                                want.traction_shear_two);
                    check_field("damage_out", {1'b0, got.damage_out},
                                {1'b0, want.damage_out});
                    check_field("damage_advanced", {31'd0, got.damage_advanced},
                                {31'd0, want.damage_advanced});
                    check_field("secant_scale", {1'b0, got.secant_scale},
                                {1'b0, want.secant_scale});
                    check_field("damage_slope", {1'b0, got.damage_slope},
                                {1'b0, want.damage_slope});
                    check_field("normal_by_damage", got.normal_by_damage,
                                want.normal_by_damage);
                    check_field("shear_one_by_damage", got.shear_one_by_damage,
                                want.shear_one_by_damage);
                    check_field("shear_two_by_damage", got.shear_two_by_damage,
                                want.shear_two_by_damage);
                end
            end
            pending <= traction_queue.size();
        end
    end

endmodule

// File: verif/exponential_cohesive_traction_tb.sv
`timescale 1ns / 1ps

module exponential_cohesive_traction_tb import ect_pkg::*;;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [1:0]   i_cfg_index;
    logic [30:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [287:0] o_m_tdata;
    int           fail_count;
    int           pending;
    int           cycles = 0;
    int           items_sent = 0;
    int           settings_run = 0;
    bit           idle_on = 1'b1;
    bit           hold_req = 1'b0;

    exponential_cohesive_traction dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    exponential_cohesive_traction_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item, with a random gap first while idle_on is set, and wait for its acceptance
    task automatic send_item(input logic [30:0] eff, input logic [30:0] old,
                             input logic [31:0] sep_n, input logic [31:0] pen_n,
                             input logic [31:0] sep_1, input logic [31:0] sep_2);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, sep_2, sep_1, pen_n, sep_n, old, eff};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Wait until every expected result has come back, then let the pipe settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [30:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [30:0] inv, input logic [30:0] coh,
                                input logic [30:0] pen, input logic [30:0] en);
        write_reg(CFG_INVERSE_LENGTH, inv);
        write_reg(CFG_COHESIVE_STIFFNESS, coh);
        write_reg(CFG_CONTACT_STIFFNESS, pen);
        write_reg(CFG_PENETRATION_ENABLE, en);
        settings_run++;
    endtask

    function automatic logic [31:0] rand_sep();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // Random item, its effective separation mostly in 0 to 40.0 (Q16.16)
    task automatic send_random();
        logic [30:0] eff;
        logic [30:0] old;
        case ($urandom_range(0, 5))
            0:       eff = 31'($urandom());
            1:       eff = 31'($urandom_range(0, 1 << 16));
            default: eff = 31'($urandom_range(0, 40 << 16));
        endcase
        case ($urandom_range(0, 5))
            0:       old = 31'($urandom());
            1:       old = 31'($urandom_range(0, 1)) ? DMG_ONE : 31'd0;
            default: old = 31'($urandom_range(0, 1 << 30));
        endcase
        send_item(eff, old, rand_sep(), rand_sep(), rand_sep(), rand_sep());
    endtask

    task automatic send_directed();
        send_item(31'd0, 31'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_item(31'h7FFF_FFFF, 31'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_item(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_item(31'd65536, 31'd0, 32'd65536, 32'hFFFF_0000, 32'd1, 32'hFFFF_FFFF);
        send_item(31'd32768, DMG_ONE, 32'd100000, 32'd100000, 32'd3, 32'hFFFF_FFFD);
        // damage above one saturates
        send_item(31'd131072, DMG_ONE + 31'd1, 32'd65536, 32'd65536, 32'd65536, 32'd2);
        // exponent large enough to give full damage
        send_item(31'd32 << 16, 31'd0, 32'd65536, 32'hFFFE_0000, 32'd7, 32'd9);
        send_item((31'd32 << 16) - 31'd1, 31'd0, 32'h0001_8000, 32'd5, 32'd5, 32'd5);
        send_item(31'd1, 31'd0, 32'hFFFF_8000, 32'h0000_8000, 32'd0, 32'd0);
        // trial below old damage: no advance
        send_item(31'd1000, 31'd1 << 29, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
    endtask

    // Receiver: random stalls per item while idle_on is set, one long hold-off on request
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_INVERSE_LENGTH;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults
        send_directed();
        drain();
        // extremes, penalty on
        load_setting(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
        send_directed();
        drain();
        // zero inverse length, stray bits in the enable word
        load_setting(31'd0, 31'd0, 31'd65536, 31'h7FFF_FFFE);
        send_directed();
        drain();
        load_setting(31'd1, 31'd65536, 31'd0, 31'd1);

        // random phases with varied settings
        for (int phase = 0; phase < 8; phase++) begin
            idle_on = (phase % 3) != 2;
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            repeat (135) send_random();
            drain();
            case (phase % 4)
                0:       load_setting(31'd65536, 31'($urandom()), 31'($urandom()), 31'd1);
                1:       load_setting(31'($urandom_range(1, 1 << 20)),
                                      31'($urandom_range(0, 1 << 20)),
                                      31'($urandom_range(0, 1 << 20)), 31'($urandom()));
                2:       load_setting(31'($urandom()), 31'($urandom()), 31'd0, 31'd0);
                default: load_setting(31'd1 << 14, 31'd1 << 18, 31'd1 << 16, 31'd1);
            endcase
        end

        $display("sent %0d items over %0d register settings, one long output stall",
                 items_sent, settings_run);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/ect_pkg.sv
src/ect_exp_series.sv
src/ect_exp_power.sv
src/ect_traction.sv
src/exponential_cohesive_traction.sv
verif/exponential_cohesive_traction_checker.sv
verif/exponential_cohesive_traction_tb.sv
